[rtl/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // period store sizing
  localparam int MAX_PERIODS = 8;
  localparam int IDX_W       = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int CNT_W       = $clog2(MAX_PERIODS + 1);

  // request opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // receive phases
  localparam logic [1:0] PH_ID  = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  // command ids and masks
  localparam logic [7:0] FRAME_BIT_MASK = 8'h80;
  localparam logic [7:0] GROUP_MASK     = 8'hF0;
  localparam logic [7:0] CMD_SELECT_GRP = 8'h70;
  localparam logic [7:0] CMD_DEBUG      = 8'h01;
  localparam logic [7:0] CMD_RUN_INSTR  = 8'h02;
  localparam logic [7:0] CMD_RUN_STEP   = 8'h03;
  localparam logic [7:0] CMD_UPLOAD     = 8'h80;
  localparam logic [7:0] MIN_UPLOAD_LEN = 8'd4;

  // action codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_SELECT    = 3'd1;
  localparam logic [2:0] ACT_TOGGLE    = 3'd2;
  localparam logic [2:0] ACT_RESET_SEQ = 3'd3;
  localparam logic [2:0] ACT_RUN_INSTR = 3'd4;
  localparam logic [2:0] ACT_RUN_STEP  = 3'd5;
  localparam logic [2:0] ACT_PERIOD    = 3'd6;

  // response codes
  localparam logic [2:0] RSP_NONE    = 3'd0;
  localparam logic [2:0] RSP_ACK     = 3'd1;
  localparam logic [2:0] RSP_UNKNOWN = 3'd2;
  localparam logic [2:0] RSP_TIMEOUT = 3'd3;
  localparam logic [2:0] RSP_INVALID = 3'd4;

  // one result item
  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  entry_index;
    logic [15:0] period;
    logic [3:0]  entry_count;
    logic [2:0]  response;
    logic        last;
  } res_t;

endpackage

[rtl/cfr_ram.sv]
// ----------------------------------------------------------------------------
// cfr_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/command_frame_receiver.sv]
// ----------------------------------------------------------------------------
// command_frame_receiver
// Parses command frames from serial bytes and timeout ticks into actions.
//
// Each request is either a received byte or one timer tick. A request is
// taken into a one-entry input register, so the next request can be taken
// while a result still waits at the output register. A byte or a tick is
// processed once the output register is free and no readback runs, giving
// at most one result. Completing a valid timer config upload (id 0x80)
// instead reads the stored periods back from the period RAM: each entry
// is a RAM read, then an output load that waits out any output stall,
// and the acknowledge follows the last entry. Periods are written into
// the RAM as their high bytes arrive; the readback only starts after the
// final write has landed.
// timeout_ticks is written through the cfg port, which is always ready.
// ----------------------------------------------------------------------------
module command_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  input  logic        sequencer_running,
  // result requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [3:0]  entry_index,
  output logic [15:0] period,
  output logic [3:0]  entry_count,
  output logic [2:0]  response,
  output logic        last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_ACK  = 2'd3;

  localparam int IDX_W_L = cfr_pkg::IDX_W;
  localparam int CNT_W_L = cfr_pkg::CNT_W;

  // configuration
  logic [15:0] timeout_ticks;

  // input register
  logic        in_full;
  logic        in_opcode;
  logic [7:0]  in_byte;
  logic        in_running;

  // receiver state
  logic [1:0]  phase, phase_next;
  logic [7:0]  current_id, current_id_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  payload_position, payload_position_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [15:0] tick_count, tick_count_next;

  // readback sequencer
  logic [1:0]             state;
  logic [IDX_W_L-1:0]     rd_idx;
  logic [CNT_W_L-1:0]     cnt;

  // output register
  cfr_pkg::res_t out_reg, out_data;
  logic          out_load;
  logic          out_free;

  // processing signals
  logic                proc;
  logic                single_valid;
  cfr_pkg::res_t       single_res;
  logic                do_handle;
  logic                start_upload;
  logic [7:0]          h_id;
  logic [7:0]          h_len;
  logic [2:0]          h_act;
  logic [3:0]          h_idx;
  logic [2:0]          h_resp;
  logic                h_upload;
  logic [6:0]          h_half;
  logic [CNT_W_L-1:0]  h_cnt;
  logic [15:0]         tick_sat;
  logic [7:0]          pay_idx;

  // period RAM ports
  logic                wr_en;
  logic [IDX_W_L-1:0]  wr_addr;
  logic [15:0]         wr_data;
  logic [15:0]         rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_full;
  assign out_free  = !out_valid || !out_stall;
  assign proc      = in_full && (state == S_IDLE) && out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_opcode  <= opcode;
      in_byte    <= rx_byte;
      in_running <= sequencer_running;
    end
  end

  // frame parsing and command decode
  always_comb begin
    phase_next            = phase;
    current_id_next       = current_id;
    frame_length_next     = frame_length;
    bytes_left_next       = bytes_left;
    payload_position_next = payload_position;
    low_byte_hold_next    = low_byte_hold;
    tick_count_next       = tick_count;
    single_valid          = 1'b0;
    single_res            = '0;
    do_handle             = 1'b0;
    wr_en                 = 1'b0;
    wr_data               = {in_byte, low_byte_hold};
    h_id                  = current_id;
    h_len                 = frame_length;
    tick_sat              = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
    pay_idx               = (payload_position - 8'd2) >> 1;
    wr_addr               = pay_idx[IDX_W_L-1:0];

    if (proc) begin
      if (in_opcode == cfr_pkg::OP_TICK) begin
        // timeout counting while a frame is open
        if (phase != cfr_pkg::PH_ID) begin
          tick_count_next = tick_sat;
          if (tick_sat >= timeout_ticks) begin
            phase_next          = cfr_pkg::PH_ID;
            single_valid        = 1'b1;
            single_res.response = cfr_pkg::RSP_TIMEOUT;
            single_res.last     = 1'b1;
          end
        end
      end else begin
        unique case (phase)
          cfr_pkg::PH_LEN: begin
            frame_length_next     = in_byte;
            bytes_left_next       = in_byte;
            payload_position_next = 8'd0;
            h_len                 = in_byte;
            if (in_byte == 8'd0) begin
              phase_next = cfr_pkg::PH_ID;
              do_handle  = 1'b1;
            end else begin
              phase_next = cfr_pkg::PH_PAY;
            end
          end
          cfr_pkg::PH_PAY: begin
            // two skipped bytes, then little-endian periods
            if (payload_position >= 8'd2) begin
              if (!payload_position[0]) begin
                low_byte_hold_next = in_byte;
              end else if (pay_idx < 8'(cfr_pkg::MAX_PERIODS)) begin
                wr_en = 1'b1;
              end
            end
            if (payload_position != 8'hFF) begin
              payload_position_next = payload_position + 8'd1;
            end
            if (bytes_left != 8'd0) begin
              bytes_left_next = bytes_left - 8'd1;
            end
            if (bytes_left_next == 8'd0) begin
              phase_next = cfr_pkg::PH_ID;
              do_handle  = 1'b1;
            end
          end
          default: begin
            // id byte, also the unused phase code
            current_id_next = in_byte;
            h_id            = in_byte;
            if ((in_byte & cfr_pkg::FRAME_BIT_MASK) == 8'd0) begin
              phase_next = cfr_pkg::PH_ID;
              do_handle  = 1'b1;
            end else begin
              phase_next      = cfr_pkg::PH_LEN;
              tick_count_next = 16'd0;
            end
          end
        endcase
      end
    end

    // command decode
    h_act    = cfr_pkg::ACT_NONE;
    h_idx    = 4'd0;
    h_resp   = cfr_pkg::RSP_UNKNOWN;
    h_upload = 1'b0;
    h_half   = h_len[7:1] - 7'd1;
    if (h_half > 7'(cfr_pkg::MAX_PERIODS)) begin
      h_cnt = CNT_W_L'(cfr_pkg::MAX_PERIODS);
    end else begin
      h_cnt = CNT_W_L'(h_half);
    end
    if ((h_id & cfr_pkg::GROUP_MASK) == cfr_pkg::CMD_SELECT_GRP) begin
      h_act  = cfr_pkg::ACT_SELECT;
      h_idx  = h_id[3:0];
      h_resp = cfr_pkg::RSP_ACK;
    end else if (h_id == cfr_pkg::CMD_DEBUG) begin
      h_act  = in_running ? cfr_pkg::ACT_TOGGLE : cfr_pkg::ACT_RESET_SEQ;
      h_resp = cfr_pkg::RSP_ACK;
    end else if (h_id == cfr_pkg::CMD_RUN_INSTR) begin
      h_act  = cfr_pkg::ACT_RUN_INSTR;
      h_resp = cfr_pkg::RSP_ACK;
    end else if (h_id == cfr_pkg::CMD_RUN_STEP) begin
      h_act  = cfr_pkg::ACT_RUN_STEP;
      h_resp = cfr_pkg::RSP_ACK;
    end else if (h_id == cfr_pkg::CMD_UPLOAD) begin
      if ((h_len < cfr_pkg::MIN_UPLOAD_LEN) || h_len[0]) begin
        h_resp = cfr_pkg::RSP_INVALID;
      end else begin
        h_upload = 1'b1;
      end
    end

    start_upload = do_handle && h_upload;
    if (do_handle && !h_upload) begin
      single_valid           = 1'b1;
      single_res.action      = h_act;
      single_res.entry_index = h_idx;
      single_res.response    = h_resp;
      single_res.last        = 1'b1;
    end
  end

  // receiver state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= cfr_pkg::PH_ID;
      current_id       <= 8'd0;
      frame_length     <= 8'd0;
      bytes_left       <= 8'd0;
      payload_position <= 8'd0;
      low_byte_hold    <= 8'd0;
      tick_count       <= 16'd0;
    end else begin
      phase            <= phase_next;
      current_id       <= current_id_next;
      frame_length     <= frame_length_next;
      bytes_left       <= bytes_left_next;
      payload_position <= payload_position_next;
      low_byte_hold    <= low_byte_hold_next;
      tick_count       <= tick_count_next;
    end
  end

  // period store
  cfr_ram #(
    .WIDTH (16),
    .DEPTH (cfr_pkg::MAX_PERIODS)
  ) u_period_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // output select
  always_comb begin
    out_load = 1'b0;
    out_data = '0;
    unique case (state)
      S_IDLE: begin
        out_load = single_valid;
        out_data = single_res;
      end
      S_EMIT: begin
        out_load             = out_free;
        out_data.action      = cfr_pkg::ACT_PERIOD;
        out_data.entry_index = 4'(rd_idx);
        out_data.period      = rd_data;
        out_data.entry_count = 4'(cnt);
      end
      S_ACK: begin
        out_load             = out_free;
        out_data.entry_count = 4'(cnt);
        out_data.response    = cfr_pkg::RSP_ACK;
        out_data.last        = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // readback sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start_upload) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (CNT_W_L'(rd_idx) == cnt - CNT_W_L'(1)) begin
              state <= S_ACK;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_ACK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_upload) begin
      rd_idx <= '0;
      cnt    <= h_cnt;
    end else if ((state == S_EMIT) && out_free) begin
      rd_idx <= rd_idx + IDX_W_L'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= out_data;
    end
  end

  assign action      = out_reg.action;
  assign entry_index = out_reg.entry_index;
  assign period      = out_reg.period;
  assign entry_count = out_reg.entry_count;
  assign response    = out_reg.response;
  assign last        = out_reg.last;

  // no store write while the store is being read back
  a_no_write_in_readback: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !wr_en)
    else $error("period store written during readback");

  // only period entries are sent without last
  a_last_only_on_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.last) |-> (out_reg.action == cfr_pkg::ACT_PERIOD))
    else $error("non-entry result without last");

  // read index stays inside the upload count
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD) || (state == S_EMIT)) |-> (CNT_W_L'(rd_idx) < cnt))
    else $error("readback index beyond entry count");

  // each entry is loaded only after its RAM read cycle
  a_emit_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (($past(state) == S_RD) || ($past(state) == S_EMIT)))
    else $error("entry emitted without a RAM read");

endmodule

[bench/cfr_checker.sv]
// ----------------------------------------------------------------------------
// cfr_checker
// Watches the request, result and config channels of the command frame
// receiver, predicts the result stream from the accepted requests and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cfr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  input  logic        sequencer_running,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  entry_index,
  input  logic [15:0] period,
  input  logic [3:0]  entry_count,
  input  logic [2:0]  response,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  // predicted results not yet seen on the output
  cfr_pkg::res_t awaited_results[$];
  int   errors  = 0;
  int   waiting = 0;

  // mirror of the receiver state
  logic [1:0]  recv_phase;
  logic [7:0]  frame_id;
  logic [7:0]  frame_len;
  logic [7:0]  payload_left;
  logic [7:0]  payload_pos;
  logic [7:0]  low_byte;
  logic [15:0] period_mem [cfr_pkg::MAX_PERIODS];
  logic [15:0] tick_total;
  logic [15:0] timeout_limit;

  assign fail_count = errors;
  assign pending    = waiting;

  task automatic push_result(input logic [2:0] act, input logic [3:0] idx,
                             input logic [15:0] per, input logic [3:0] cnt,
                             input logic [2:0] rsp, input logic fin);
    cfr_pkg::res_t r;
    r.action      = act;
    r.entry_index = idx;
    r.period      = per;
    r.entry_count = cnt;
    r.response    = rsp;
    r.last        = fin;
    awaited_results.push_back(r);
  endtask

  // results of a completed command
  task automatic decode_command(input logic run);
    int cnt;
    if ((frame_id & cfr_pkg::GROUP_MASK) == cfr_pkg::CMD_SELECT_GRP) begin
      push_result(cfr_pkg::ACT_SELECT, frame_id[3:0], 16'd0, 4'd0, cfr_pkg::RSP_ACK, 1'b1);
    end else if (frame_id == cfr_pkg::CMD_DEBUG) begin
      push_result(run ? cfr_pkg::ACT_TOGGLE : cfr_pkg::ACT_RESET_SEQ, 4'd0, 16'd0, 4'd0,
                  cfr_pkg::RSP_ACK, 1'b1);
    end else if (frame_id == cfr_pkg::CMD_RUN_INSTR) begin
      push_result(cfr_pkg::ACT_RUN_INSTR, 4'd0, 16'd0, 4'd0, cfr_pkg::RSP_ACK, 1'b1);
    end else if (frame_id == cfr_pkg::CMD_RUN_STEP) begin
      push_result(cfr_pkg::ACT_RUN_STEP, 4'd0, 16'd0, 4'd0, cfr_pkg::RSP_ACK, 1'b1);
    end else if (frame_id == cfr_pkg::CMD_UPLOAD) begin
      if (frame_len < cfr_pkg::MIN_UPLOAD_LEN || frame_len[0]) begin
        push_result(cfr_pkg::ACT_NONE, 4'd0, 16'd0, 4'd0, cfr_pkg::RSP_INVALID, 1'b1);
      end else begin
        // two skipped bytes, then one period per byte pair, capped
        cnt = (int'(frame_len) - 2) / 2;
        if (cnt > cfr_pkg::MAX_PERIODS) cnt = cfr_pkg::MAX_PERIODS;
        for (int i = 0; i < cnt; i++)
          push_result(cfr_pkg::ACT_PERIOD, i[3:0], period_mem[i], cnt[3:0],
                      cfr_pkg::RSP_NONE, 1'b0);
        push_result(cfr_pkg::ACT_NONE, 4'd0, 16'd0, cnt[3:0], cfr_pkg::RSP_ACK, 1'b1);
      end
    end else begin
      push_result(cfr_pkg::ACT_NONE, 4'd0, 16'd0, 4'd0, cfr_pkg::RSP_UNKNOWN, 1'b1);
    end
  endtask

  // one accepted request: byte or tick
  task automatic parse_request(input logic op, input logic [7:0] b, input logic run);
    int slot;
    if (op == cfr_pkg::OP_TICK) begin
      // ticks only count while a frame is open
      if (recv_phase != cfr_pkg::PH_ID) begin
        if (tick_total != 16'hFFFF) tick_total = tick_total + 16'd1;
        if (tick_total >= timeout_limit) begin
          recv_phase = cfr_pkg::PH_ID;
          push_result(cfr_pkg::ACT_NONE, 4'd0, 16'd0, 4'd0, cfr_pkg::RSP_TIMEOUT, 1'b1);
        end
      end
    end else if (recv_phase == cfr_pkg::PH_LEN) begin
      frame_len    = b;
      payload_left = b;
      payload_pos  = 8'd0;
      if (b == 8'd0) begin
        recv_phase = cfr_pkg::PH_ID;
        decode_command(run);
      end else begin
        recv_phase = cfr_pkg::PH_PAY;
      end
    end else if (recv_phase == cfr_pkg::PH_PAY) begin
      // little-endian periods after the two skipped bytes
      if (payload_pos >= 8'd2) begin
        if (!payload_pos[0]) begin
          low_byte = b;
        end else begin
          slot = (int'(payload_pos) - 2) >> 1;
          if (slot < cfr_pkg::MAX_PERIODS) period_mem[slot] = {b, low_byte};
        end
      end
      if (payload_pos != 8'hFF) payload_pos = payload_pos + 8'd1;
      if (payload_left != 8'd0) payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
        recv_phase = cfr_pkg::PH_ID;
        decode_command(run);
      end
    end else begin
      frame_id = b;
      if ((b & cfr_pkg::FRAME_BIT_MASK) == 8'd0) begin
        recv_phase = cfr_pkg::PH_ID;
        decode_command(run);
      end else begin
        recv_phase = cfr_pkg::PH_LEN;
        tick_total = 16'd0;
      end
    end
  endtask

  task automatic compare_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      errors++;
    end
  endtask

  // sample channels at the rising edge: results first, then requests
  always @(posedge clk) begin : monitor
    cfr_pkg::res_t want;
    if (rst) begin
      recv_phase    = cfr_pkg::PH_ID;
      frame_id      = 8'd0;
      frame_len     = 8'd0;
      payload_left  = 8'd0;
      payload_pos   = 8'd0;
      low_byte      = 8'd0;
      tick_total    = 16'd0;
      timeout_limit = 16'd1;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: expected none, got act %0d idx %0d per %0h cnt %0d rsp %0d last %0d",
                   $time, action, entry_index, period, entry_count, response, last);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("action", 16'(want.action), 16'(action));
          compare_field("entry_index", 16'(want.entry_index), 16'(entry_index));
          compare_field("period", want.period, period);
          compare_field("entry_count", 16'(want.entry_count), 16'(entry_count));
          compare_field("response", 16'(want.response), 16'(response));
          compare_field("last", 16'(want.last), 16'(last));
        end
      end
      if (in_valid && !in_stall) parse_request(opcode, rx_byte, sequencer_running);
    end
    waiting = awaited_results.size();
  end

endmodule

[bench/command_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// command_frame_receiver_tb
// Drives byte and tick requests into the command frame receiver: a directed
// pass over every command, bad lengths, zero length and timeouts, then
// random frames under several timeout settings, most with result stalls
// and some with random request gaps. Checking is done by cfr_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module command_frame_receiver_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  logic        clk               = 1'b0;
  logic        rst               = 1'b1;
  logic        cfg_valid         = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data          = 16'd0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic        opcode            = 1'b0;
  logic [7:0]  rx_byte           = 8'd0;
  logic        sequencer_running = 1'b0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [2:0]  action;
  logic [3:0]  entry_index;
  logic [15:0] period;
  logic [3:0]  entry_count;
  logic [2:0]  response;
  logic        last;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   req_count   = 0;
  int   timeout_now = 1;
  int   stall_left  = 0;
  logic stall_on    = 1'b0;
  logic gap_on      = 1'b0;

  always #10 clk = ~clk;

  command_frame_receiver dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .rx_byte(rx_byte), .sequencer_running(sequencer_running),
    .out_valid(out_valid), .out_stall(out_stall), .action(action),
    .entry_index(entry_index), .period(period), .entry_count(entry_count),
    .response(response), .last(last)
  );

  cfr_checker frame_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .rx_byte(rx_byte), .sequencer_running(sequencer_running),
    .out_valid(out_valid), .out_stall(out_stall), .action(action),
    .entry_index(entry_index), .period(period), .entry_count(entry_count),
    .response(response), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("command_frame_receiver: mismatch");
      $finish;
    end
  end

  // result stall: mostly short bursts, a few long ones
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!stall_on || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gap_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int eff_timeout();
    return (timeout_now == 0) ? 1 : timeout_now;
  endfunction

  // one request, entered and left at a falling edge
  task automatic send_req(input logic op, input logic [7:0] b, input logic run);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode            <= op;
    rx_byte           <= b;
    sequencer_running <= run;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    req_count++;
    @(negedge clk);
  endtask

  // id, length and payload with optional ticks; a cut stops the frame early
  // and lets ticks time it out
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input int tick_pct, input int cut);
    int ticks_seen;
    ticks_seen = 0;
    send_req(cfr_pkg::OP_BYTE, id, 1'($urandom_range(0, 1)));
    for (int n = 0; n <= len; n++) begin
      if (n == cut) begin
        repeat (eff_timeout() - ticks_seen)
          send_req(cfr_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        return;
      end
      if ($urandom_range(0, 99) < tick_pct) begin
        send_req(cfr_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        ticks_seen++;
        if (ticks_seen >= eff_timeout()) return;
      end
      send_req(cfr_pkg::OP_BYTE, (n == 0) ? len : 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    timeout_now = int'(value);
  endtask

  function automatic logic [7:0] upload_len();
    if ($urandom_range(0, 9) < 7) return 8'(2 * $urandom_range(2, 4));
    return 8'(2 * $urandom_range(5, 11));
  endfunction

  // mostly well-formed frames, some broken ones and stray ticks
  task automatic random_traffic(input int n_items);
    int          start;
    int          r;
    logic [7:0]  id;
    logic [7:0]  len;
    start = req_count;
    while (req_count - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        case ($urandom_range(0, 3))
          0:       id = cfr_pkg::CMD_SELECT_GRP | 8'($urandom_range(0, 15));
          1:       id = cfr_pkg::CMD_DEBUG;
          2:       id = cfr_pkg::CMD_RUN_INSTR;
          default: id = cfr_pkg::CMD_RUN_STEP;
        endcase
        send_req(cfr_pkg::OP_BYTE, id, 1'($urandom_range(0, 1)));
      end else if (r < 18) begin
        send_req(cfr_pkg::OP_BYTE, 8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (r < 21) begin
        send_req(cfr_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 66) begin
        send_frame(cfr_pkg::CMD_UPLOAD, upload_len(), 4, -1);
      end else if (r < 74) begin
        // bad upload length: too short or odd
        if ($urandom_range(0, 1) == 0) len = 8'($urandom_range(0, 3));
        else len = 8'(2 * $urandom_range(2, 10) + 1);
        send_frame(cfr_pkg::CMD_UPLOAD, len, 4, -1);
      end else if (r < 82) begin
        send_frame(8'($urandom_range(129, 255)), 8'($urandom_range(0, 6)), 4, -1);
      end else if (eff_timeout() <= 16) begin
        len = upload_len();
        send_frame(cfr_pkg::CMD_UPLOAD, len, 4, $urandom_range(0, len));
      end else begin
        send_frame(cfr_pkg::CMD_UPLOAD, upload_len(), 0, -1);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every command under the reset timeout of one tick
    send_req(cfr_pkg::OP_TICK, 8'hFF, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'h70, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h7F, 1'b1);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_DEBUG, 1'b1);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_DEBUG, 1'b0);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_RUN_INSTR, 1'b0);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_RUN_STEP, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    // long unknown id with zero length
    send_req(cfr_pkg::OP_BYTE, 8'hFF, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    // upload with zero and with odd length
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'h01, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'hAA, 1'b0);
    // single entry upload with an all-ones period
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h04, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h12, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'h34, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_req(cfr_pkg::OP_BYTE, 8'hFF, 1'b0);
    // timeouts in length and in payload
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b0);
    send_req(cfr_pkg::OP_TICK, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h06, 1'b0);
    send_req(cfr_pkg::OP_TICK, 8'h00, 1'b1);

    // zero timeout register acts as one tick
    write_timeout(16'h0000);
    send_req(cfr_pkg::OP_BYTE, 8'h9C, 1'b0);
    send_req(cfr_pkg::OP_TICK, 8'h00, 1'b0);

    // widest timeout: ticks inside a frame do not abort it
    write_timeout(16'hFFFF);
    send_req(cfr_pkg::OP_BYTE, cfr_pkg::CMD_UPLOAD, 1'b0);
    send_req(cfr_pkg::OP_TICK, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h04, 1'b0);
    send_req(cfr_pkg::OP_TICK, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);
    send_req(cfr_pkg::OP_BYTE, 8'h00, 1'b0);

    // random phases over several timeout settings
    write_timeout(16'($urandom_range(2, 6)));
    gap_on = 1'b1;
    stall_on <= 1'b1;
    random_traffic(35);

    write_timeout(16'd1);
    gap_on = 1'b0;
    stall_on <= 1'b0;
    random_traffic(30);

    write_timeout(16'hFFFF);
    gap_on = 1'b1;
    stall_on <= 1'b1;
    random_traffic(35);

    write_timeout(16'($urandom_range(7, 300)));
    gap_on = 1'b0;
    stall_on <= 1'b1;
    random_traffic(30);

    wait_drained();
    if (fail_count == 0)
      $display("command_frame_receiver: match");
    else
      $display("command_frame_receiver: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/cfr_pkg.sv
rtl/cfr_ram.sv
rtl/command_frame_receiver.sv
bench/cfr_checker.sv
bench/command_frame_receiver_tb.sv
